[src/pdc_pkg.sv]
package pdc_pkg;

  // Width of the free-running capture counter and of the port fields.
  localparam int CountWidth = 32;
  localparam int FieldWidth = 32;
  localparam int TimeWidth  = (CountWidth < FieldWidth) ? CountWidth : FieldWidth;

  // Serial datapath: one digit of DigitWidth bits moves per cycle.
  localparam int DigitWidth    = 4;
  localparam int NumDigits     = (TimeWidth + DigitWidth - 1) / DigitWidth;
  localparam int SerWidth      = NumDigits * DigitWidth;
  localparam int DigitCntWidth = $clog2(NumDigits);

  // Duty is built from two decimal digits, ten add-compare steps each.
  localparam int DutyWidth      = 7;
  localparam int StepsPerDigit  = 10;
  localparam int StepCntWidth   = $clog2(2 * StepsPerDigit);
  localparam logic [DutyWidth-1:0] TensWeight = DutyWidth'(10);
  localparam logic [DutyWidth-1:0] OnesWeight = DutyWidth'(1);

  typedef logic [DigitWidth-1:0] digit_t;

  typedef enum logic [1:0] {
    PH_RISE1,
    PH_FALL,
    PH_RISE2
  } edge_phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF,
    ST_DIV,
    ST_HOLD
  } pdc_state_t;

  // Difference digits streamed from the capture store to the divider.
  typedef struct packed {
    logic   shift;
    digit_t period;
    digit_t high;
  } pdc_digits_t;

  // Outcome of the ordering check, valid in the cycle that done is high.
  typedef struct packed {
    logic done;
    logic ok;
  } pdc_check_t;

endpackage

[src/pdc_cap_if.sv]
interface pdc_cap_if
  import pdc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [FieldWidth-1:0] capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

[src/pdc_res_if.sv]
interface pdc_res_if
  import pdc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [FieldWidth-1:0] period_ticks;
  logic [FieldWidth-1:0] high_ticks;
  logic [DutyWidth-1:0]  duty_percent;
  logic                  measure_ok;

  modport source (output valid, output period_ticks, output high_ticks,
                  output duty_percent, output measure_ok, input ready);
  modport sink   (input valid, input period_ticks, input high_ticks,
                  input duty_percent, input measure_ok, output ready);
endinterface

[src/pdc_capture.sv]
module pdc_capture
  import pdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [FieldWidth-1:0] capture_time,
  output edge_phase_t           phase,
  output pdc_digits_t           digits,
  output pdc_check_t            check
);

  logic [SerWidth-1:0]      first_sr;
  logic [SerWidth-1:0]      fall_sr;
  logic [SerWidth-1:0]      rise_sr;
  logic                     busy;
  logic [DigitCntWidth-1:0] cnt;
  logic                     borrow_p;
  logic                     borrow_h;
  logic                     borrow_c;
  logic                     nz_h;
  logic                     nz_c;

  logic [DigitWidth:0] sub_p;
  logic [DigitWidth:0] sub_h;
  logic [DigitWidth:0] sub_c;
  logic                last_digit;
  logic [SerWidth-1:0] time_ext;

  assign time_ext = SerWidth'(capture_time[TimeWidth-1:0]);

  // Three serial subtractors: period, high time, and fall against second rise.
  assign sub_p = {1'b0, rise_sr[DigitWidth-1:0]} - {1'b0, first_sr[DigitWidth-1:0]}
                 - {{DigitWidth{1'b0}}, borrow_p};
  assign sub_h = {1'b0, fall_sr[DigitWidth-1:0]} - {1'b0, first_sr[DigitWidth-1:0]}
                 - {{DigitWidth{1'b0}}, borrow_h};
  assign sub_c = {1'b0, rise_sr[DigitWidth-1:0]} - {1'b0, fall_sr[DigitWidth-1:0]}
                 - {{DigitWidth{1'b0}}, borrow_c};

  assign last_digit = (cnt == DigitCntWidth'(NumDigits - 1));

  assign digits.shift  = busy;
  assign digits.period = sub_p[DigitWidth-1:0];
  assign digits.high   = sub_h[DigitWidth-1:0];

  // Phase register and the difference pass control.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_RISE1;
      busy       <= 1'b0;
      cnt        <= '0;
      check.done <= 1'b0;
      check.ok   <= 1'b0;
    end else begin
      check.done <= 1'b0;
      if (load) begin
        case (phase)
          PH_FALL: begin
            phase <= PH_RISE2;
          end
          PH_RISE2: begin
            phase <= PH_RISE1;
            busy  <= 1'b1;
            cnt   <= '0;
          end
          default: begin
            phase <= PH_FALL;
          end
        endcase
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last_digit) begin
          busy       <= 1'b0;
          check.done <= 1'b1;
          // Strictly increasing means both differences are positive.
          check.ok   <= !sub_h[DigitWidth] && (nz_h || (sub_h[DigitWidth-1:0] != '0)) &&
                        !sub_c[DigitWidth] && (nz_c || (sub_c[DigitWidth-1:0] != '0));
        end
      end
    end
  end

  // Timestamp shift registers and the per-digit borrow and zero flags.
  always_ff @(posedge clk) begin
    if (load) begin
      case (phase)
        PH_FALL:  fall_sr <= time_ext;
        PH_RISE2: rise_sr <= time_ext;
        default:  first_sr <= time_ext;
      endcase
      borrow_p <= 1'b0;
      borrow_h <= 1'b0;
      borrow_c <= 1'b0;
      nz_h     <= 1'b0;
      nz_c     <= 1'b0;
    end else if (busy) begin
      first_sr <= first_sr >> DigitWidth;
      fall_sr  <= fall_sr >> DigitWidth;
      rise_sr  <= rise_sr >> DigitWidth;
      borrow_p <= sub_p[DigitWidth];
      borrow_h <= sub_h[DigitWidth];
      borrow_c <= sub_c[DigitWidth];
      nz_h     <= nz_h || (sub_h[DigitWidth-1:0] != '0);
      nz_c     <= nz_c || (sub_c[DigitWidth-1:0] != '0);
    end
  end

endmodule

[src/pdc_duty_div.sv]
module pdc_duty_div
  import pdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  pdc_digits_t           digits,
  input  logic                  start,
  output logic                  done,
  output logic [FieldWidth-1:0] period_ticks,
  output logic [FieldWidth-1:0] high_ticks,
  output logic [DutyWidth-1:0]  duty
);

  logic [SerWidth-1:0]      period_sr;
  logic [SerWidth-1:0]      high_sr;
  logic [SerWidth-1:0]      rem_sr;
  logic [SerWidth-1:0]      acc_sr;
  logic [SerWidth-1:0]      diff_sr;
  logic                     busy;
  logic [DigitCntWidth-1:0] cnt;
  logic [StepCntWidth-1:0]  step;
  logic                     carry;
  logic                     borrow;

  logic [DigitWidth:0]  sum_d;
  logic [DigitWidth:0]  sub_d;
  logic                 last_digit;
  logic                 ge;
  logic [SerWidth-1:0]  acc_sum;
  logic [SerWidth-1:0]  acc_sub;
  logic [SerWidth-1:0]  acc_new;
  logic [DutyWidth-1:0] weight;

  // One digit of s = acc + rem and of s - period per cycle.
  assign sum_d = {1'b0, acc_sr[DigitWidth-1:0]} + {1'b0, rem_sr[DigitWidth-1:0]}
                 + {{DigitWidth{1'b0}}, carry};
  assign sub_d = {1'b0, sum_d[DigitWidth-1:0]} - {1'b0, period_sr[DigitWidth-1:0]}
                 - {{DigitWidth{1'b0}}, borrow};

  assign last_digit = (cnt == DigitCntWidth'(NumDigits - 1));
  assign acc_sum    = {sum_d[DigitWidth-1:0], acc_sr[SerWidth-1:DigitWidth]};
  assign acc_sub    = {sub_d[DigitWidth-1:0], diff_sr[SerWidth-1:DigitWidth]};
  // The sum reaches the period when it carried out or the subtraction did not borrow.
  assign ge         = sum_d[DigitWidth] || !sub_d[DigitWidth];
  assign acc_new    = ge ? acc_sub : acc_sum;
  assign weight     = (step < StepCntWidth'(StepsPerDigit)) ? TensWeight : OnesWeight;

  assign period_ticks = FieldWidth'(period_sr[TimeWidth-1:0]);
  assign high_ticks   = FieldWidth'(high_sr[TimeWidth-1:0]);

  // Step and digit counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        step <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last_digit) begin
          cnt  <= '0;
          step <= step + 1'b1;
          if (step == StepCntWidth'(2 * StepsPerDigit - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  // Operand shift registers, the accumulator and the duty count.
  always_ff @(posedge clk) begin
    if (digits.shift) begin
      period_sr <= {digits.period, period_sr[SerWidth-1:DigitWidth]};
      high_sr   <= {digits.high, high_sr[SerWidth-1:DigitWidth]};
      rem_sr    <= {digits.high, rem_sr[SerWidth-1:DigitWidth]};
    end else if (start) begin
      acc_sr <= '0;
      duty   <= '0;
      carry  <= 1'b0;
      borrow <= 1'b0;
    end else if (busy) begin
      period_sr <= {period_sr[DigitWidth-1:0], period_sr[SerWidth-1:DigitWidth]};
      rem_sr    <= {rem_sr[DigitWidth-1:0], rem_sr[SerWidth-1:DigitWidth]};
      diff_sr   <= acc_sub;
      if (last_digit) begin
        carry  <= 1'b0;
        borrow <= 1'b0;
        if (ge) begin
          duty <= duty + weight;
        end
        if (step == StepCntWidth'(StepsPerDigit - 1)) begin
          // Tens digit finished: its remainder feeds the ones digit.
          rem_sr <= acc_new;
          acc_sr <= '0;
        end else begin
          acc_sr <= acc_new;
        end
      end else begin
        acc_sr <= acc_sum;
        carry  <= sum_d[DigitWidth];
        borrow <= sub_d[DigitWidth];
      end
    end
  end

endmodule

[src/pwm_period_duty_capture.sv]
// Channel  Role    Handshake     Payload
// capture  sink    valid/ready   capture_time
// result   source  valid/ready   period_ticks, high_ticks, duty_percent, measure_ok
//
// A first-rise or fall request is taken whenever the block is idle. The second-rise
// request starts a serial difference pass over NumDigits digits (8 at a 32-bit
// count), then, for an ordered set, 20 add-compare steps over NumDigits digits each
// in the duty divider before the result is written; a rejected set skips the divider.
// Reset is synchronous and returns the edge phase to the first rise.
// A result waits in the output register; a stalled sink holds the block
// before its next result is written, and captures stay blocked while busy.
module pwm_period_duty_capture
  import pdc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  pdc_cap_if.sink   capture,
  pdc_res_if.source result
);

  pdc_state_t  state;
  pdc_state_t  state_next;
  edge_phase_t phase;
  pdc_digits_t digits;
  pdc_check_t  check;
  logic        cap_load;
  logic        div_start;
  logic        div_done;
  logic        load_out;
  logic        meas_ok;
  logic        out_valid;

  logic [FieldWidth-1:0] div_period;
  logic [FieldWidth-1:0] div_high;
  logic [DutyWidth-1:0]  div_duty;
  logic [FieldWidth-1:0] out_period;
  logic [FieldWidth-1:0] out_high;
  logic [DutyWidth-1:0]  out_duty;
  logic                  out_ok;

  assign capture.ready = (state == ST_IDLE);
  assign cap_load      = capture.valid && capture.ready;

  pdc_capture u_capture (
    .clk          (clk),
    .rst          (rst),
    .load         (cap_load),
    .capture_time (capture.capture_time),
    .phase        (phase),
    .digits       (digits),
    .check        (check)
  );

  pdc_duty_div u_duty_div (
    .clk          (clk),
    .rst          (rst),
    .digits       (digits),
    .start        (div_start),
    .done         (div_done),
    .period_ticks (div_period),
    .high_ticks   (div_high),
    .duty         (div_duty)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and strobes.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cap_load && (phase == PH_RISE2)) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (check.done) begin
          if (check.ok) begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Ordering outcome of the current set.
  always_ff @(posedge clk) begin
    if (check.done) begin
      meas_ok <= check.ok;
    end
  end

  // Output register: a rejected set reports all fields zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_period <= meas_ok ? div_period : '0;
      out_high   <= meas_ok ? div_high : '0;
      out_duty   <= meas_ok ? div_duty : '0;
      out_ok     <= meas_ok;
    end
  end

  assign result.valid        = out_valid;
  assign result.period_ticks = out_period;
  assign result.high_ticks   = out_high;
  assign result.duty_percent = out_duty;
  assign result.measure_ok   = out_ok;

`ifndef SYNTHESIS
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.measure_ok) |->
      (result.period_ticks == '0 && result.high_ticks == '0 && result.duty_percent == '0))
    else $error("rejected set reports nonzero fields");

  a_ok_bounds: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.measure_ok) |->
      (result.high_ticks < result.period_ticks && result.duty_percent < DutyWidth'(100)))
    else $error("accepted set out of range");

  a_check_in_diff: assert property (@(posedge clk) disable iff (rst)
    check.done |-> (state == ST_DIFF))
    else $error("ordering check finished outside the difference pass");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import pdc_pkg::*;

  localparam int PercentScale = 100;
  localparam int StallLimit = 5000;
  localparam int DrainCycles = 200;

  // One measurement as the result channel presents it.
  typedef struct {
    logic [FieldWidth-1:0] period;
    logic [FieldWidth-1:0] high;
    logic [DutyWidth-1:0]  duty;
    logic                  ok;
  } pwm_meas_t;

  logic clk = 1'b0;
  logic rst;

  pdc_cap_if cap_ch ();
  pdc_res_if res_ch ();

  pwm_period_duty_capture u_top (
    .clk     (clk),
    .rst     (rst),
    .capture (cap_ch),
    .result  (res_ch)
  );

  // Timestamps waiting to be sent and measurements waiting to come back.
  logic [FieldWidth-1:0] pending_times[$];
  pwm_meas_t             meas_q[$];

  // Predictor state: edge phase and the two stored timestamps.
  edge_phase_t          phase;
  logic [TimeWidth-1:0] rise_ts;
  logic [TimeWidth-1:0] fall_ts;

  bit no_idle = 1'b0;
  int fail_cnt = 0;
  int n_requests = 0;
  int n_meas = 0;
  int n_rejected = 0;
  int send_gap = 0;
  int sink_hold = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(50, 300);
  endfunction

  // Advance the edge phase on one capture and queue a measurement on the second rise.
  function automatic void capture_edge(logic [FieldWidth-1:0] stamp);
    logic [TimeWidth-1:0] t;
    longint unsigned      per;
    longint unsigned      hi;
    pwm_meas_t            m;
    t = stamp[TimeWidth-1:0];
    if (phase == PH_FALL) begin
      fall_ts = t;
      phase = PH_RISE2;
    end else if (phase != PH_RISE2) begin
      rise_ts = t;
      phase = PH_FALL;
    end else begin
      phase = PH_RISE1;
      m.period = '0;
      m.high = '0;
      m.duty = '0;
      m.ok = 1'b0;
      if (rise_ts < fall_ts && fall_ts < t) begin
        per = longint'(t) - longint'(rise_ts);
        hi = longint'(fall_ts) - longint'(rise_ts);
        m.period = FieldWidth'(per);
        m.high = FieldWidth'(hi);
        m.duty = DutyWidth'((hi * PercentScale) / per);
        m.ok = 1'b1;
      end else begin
        n_rejected++;
      end
      meas_q.push_back(m);
      n_meas++;
    end
  endfunction

  function automatic void push_set(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    pending_times.push_back(FieldWidth'(a));
    pending_times.push_back(FieldWidth'(b));
    pending_times.push_back(FieldWidth'(c));
  endfunction

  // Mostly ordered sets of assorted sizes, the rest broken in various ways.
  function automatic void push_random_set();
    logic [31:0] base;
    logic [31:0] per;
    logic [31:0] hi;
    int          r;
    int          kind;
    r = $urandom_range(0, 99);
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      per = $urandom_range(2, 1000);
    end else if (kind < 90) begin
      per = $urandom_range(2, 32'h000f_ffff);
    end else begin
      per = $urandom_range(2, 32'hffff_ffff);
    end
    hi = $urandom_range(1, per - 1);
    base = $urandom_range(0, 32'hffff_ffff - per);
    if (r < 85) begin
      push_set(base, base + hi, base + per);
    end else if (r < 88) begin
      push_set($urandom, $urandom, $urandom);
    end else if (r < 91) begin
      // Counter wrap between the edges.
      base = $urandom_range(32'hffff_ffff - per + 1, 32'hffff_ffff);
      push_set(base, base + hi, base + per);
    end else if (r < 94) begin
      push_set(base, base, base + per);
    end else if (r < 97) begin
      push_set(base, base + per, base + per);
    end else begin
      push_set(base + per, base + hi, base);
    end
  endfunction

  // Hold the stimulus until every queued request is sent and answered.
  task automatic wait_drained();
    while (pending_times.size() > 0 || cap_ch.valid || meas_q.size() > 0) begin
      @(negedge clk);
    end
  endtask

  // Capture driver; the predictor runs on each accepted request.
  always @(posedge clk) begin
    if (rst) begin
      cap_ch.valid <= 1'b0;
      cap_ch.capture_time <= '0;
      send_gap = 0;
      phase = PH_RISE1;
      rise_ts = '0;
      fall_ts = '0;
    end else begin
      if (cap_ch.valid && cap_ch.ready) begin
        capture_edge(cap_ch.capture_time);
        n_requests++;
      end
      if (!cap_ch.valid || cap_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cap_ch.valid <= 1'b0;
        end else if (pending_times.size() > 0) begin
          cap_ch.valid <= 1'b1;
          cap_ch.capture_time <= pending_times.pop_front();
          send_gap = pick_gap();
        end else begin
          cap_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure.
  always @(posedge clk) begin
    pwm_meas_t m;
    if (rst) begin
      res_ch.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (meas_q.size() == 0) begin
          $error("result with no measurement pending");
          fail_cnt++;
        end else begin
          m = meas_q.pop_front();
          if (res_ch.period_ticks !== m.period) begin
            $error("period_ticks: expected %0d, got %0d", m.period, res_ch.period_ticks);
            fail_cnt++;
          end
          if (res_ch.high_ticks !== m.high) begin
            $error("high_ticks: expected %0d, got %0d", m.high, res_ch.high_ticks);
            fail_cnt++;
          end
          if (res_ch.duty_percent !== m.duty) begin
            $error("duty_percent: expected %0d, got %0d", m.duty, res_ch.duty_percent);
            fail_cnt++;
          end
          if (res_ch.measure_ok !== m.ok) begin
            $error("measure_ok: expected %0d, got %0d", m.ok, res_ch.measure_ok);
            fail_cnt++;
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        sink_hold = pick_gap();
      end
    end
  end

  // Watchdog on cycles where neither channel moves a request.
  always @(posedge clk) begin
    if (rst || (cap_ch.valid && cap_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed sets: duty extremes, all-ones fields and each way a set is rejected.
    push_set(32'd0, 32'd1, 32'd1000);
    push_set(32'd0, 32'hffff_fffe, 32'hffff_ffff);
    push_set(32'd0, 32'd0, 32'd0);
    push_set(32'hffff_ffff, 32'd0, 32'd1);
    push_set(32'd100, 32'd100, 32'd200);
    push_set(32'd100, 32'd150, 32'd150);
    push_set(32'd300, 32'd200, 32'd100);
    push_set(32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff);
    wait_drained();

    // Random sets: idle gaps, then a stretch with none, then gaps again.
    repeat (200) push_random_set();
    wait_drained();
    no_idle = 1'b1;
    repeat (60) push_random_set();
    wait_drained();
    no_idle = 1'b0;
    repeat (200) push_random_set();
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    if (meas_q.size() > 0) begin
      $error("%0d measurements never arrived", meas_q.size());
      fail_cnt++;
    end
    $display("Sent %0d capture requests, checked %0d measurements (%0d rejected sets).",
             n_requests, n_meas - meas_q.size(), n_rejected);
    $display("Stimulus mixed ordered sets from tiny to full-range periods with wrapped,");
    $display("equal and reversed timestamps under random gaps and backpressure.");
    if (fail_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/pdc_pkg.sv
src/pdc_cap_if.sv
src/pdc_res_if.sv
src/pdc_capture.sv
src/pdc_duty_div.sv
src/pwm_period_duty_capture.sv
tb/testbench.sv
